>>> hw/rtl/wrc4_pkg.sv
// ----------------------------------------------------------------------------
// wrc4_pkg: shared constants for the WEP RC4 keystream generator
// Field widths of the request and response items and the CSR map.
// ----------------------------------------------------------------------------
package wrc4_pkg;

   // item field widths
   localparam int IvWidth  = 24;
   localparam int PosWidth = 12;

   // CSR port geometry: 64-bit registers at byte address 8*i
   localparam int CsrDataWidth = 64;
   localparam int CsrAddrWidth = 6;

   // CSR register indexes (paddr[5:3])
   localparam logic [2:0] REG_KEY_0_7   = 3'd0;
   localparam logic [2:0] REG_KEY_8_15  = 3'd1;
   localparam logic [2:0] REG_KEY_16_23 = 3'd2;
   localparam logic [2:0] REG_KEY_24_28 = 3'd3;
   localparam logic [2:0] REG_KEY_LEN   = 3'd4;

   // secret key length limits
   localparam logic [4:0] KeyLenMin = 5'd5;
   localparam logic [4:0] KeyLenMax = 5'd29;

   // saturation value of the byte index
   localparam logic [PosWidth-1:0] PosMax = 12'hFFF;

endpackage

>>> hw/rtl/wrc4_req_if.sv
// ----------------------------------------------------------------------------
// wrc4_req_if: request channel of the WEP RC4 keystream generator
// Valid/ready channel carrying opcode, IV and error-injection request.
// ----------------------------------------------------------------------------
interface wrc4_req_if
   import wrc4_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [IvWidth-1:0]   init_vector;
   logic                 inject_error;

   modport source (output valid, output opcode, output init_vector,
                   output inject_error, input ready);
   modport sink   (input valid, input opcode, input init_vector,
                   input inject_error, output ready);
endinterface

>>> hw/rtl/wrc4_rsp_if.sv
// ----------------------------------------------------------------------------
// wrc4_rsp_if: response channel of the WEP RC4 keystream generator
// Valid/ready channel carrying keystream byte, weak-IV flag and byte index.
// ----------------------------------------------------------------------------
interface wrc4_rsp_if
   import wrc4_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [7:0]           keystream_byte;
   logic                 weak_iv;
   logic [PosWidth-1:0]  byte_position;

   modport source (output valid, output keystream_byte, output weak_iv,
                   output byte_position, input ready);
   modport sink   (input valid, input keystream_byte, input weak_iv,
                   input byte_position, output ready);
endinterface

>>> hw/rtl/wep_rc4_keystream_generator_unit.sv
// ----------------------------------------------------------------------------
// wep_rc4_keystream_generator_unit: WEP RC4 keystream source
// Per-packet key schedule and keystream generation over a 256-byte S-box.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A next item runs four steps on the
// S-box memory (read S[i], read S[j], write S[i] while reading the output
// entry, write S[j]) between the accept and delivery steps. A restart first
// fills the S-box with the identity, then runs the key schedule at four
// memory steps per entry, swaps S[1] and S[11] when error injection is
// requested, and then produces the first byte like a next item. The memory
// port takes one read and one write per cycle. The result sits in an output
// register, so the next item is accepted while it waits.
// The first item after reset must be a restart.
// ----------------------------------------------------------------------------
module wep_rc4_keystream_generator_unit
   import wrc4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   wrc4_req_if.sink                 req,
   wrc4_rsp_if.source               rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CsrAddrWidth-1:0]  paddr,
   input  logic [CsrDataWidth-1:0]  pwdata,
   output logic [CsrDataWidth-1:0]  prdata,
   output logic                     pready
);

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FILL    = 3'd1;
   localparam logic [2:0] ST_RD_A    = 3'd2;
   localparam logic [2:0] ST_RD_B    = 3'd3;
   localparam logic [2:0] ST_WR_A    = 3'd4;
   localparam logic [2:0] ST_WR_B    = 3'd5;
   localparam logic [2:0] ST_DELIVER = 3'd6;

   // what the shared swap sequence is doing
   localparam logic [1:0] MODE_KSA  = 2'd0;
   localparam logic [1:0] MODE_ERR  = 2'd1;
   localparam logic [1:0] MODE_PRGA = 2'd2;

   localparam logic [7:0] ErrAddrA = 8'd1;
   localparam logic [7:0] ErrAddrB = 8'd11;

   // ---------------------------------------------------------------------
   // CSR registers
   // ---------------------------------------------------------------------
   logic [63:0] key0_ff, key1_ff, key2_ff;
   logic [39:0] key3_ff;
   logic [4:0]  key_len_ff;
   logic        csr_wr;

   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff    <= '0;
         key1_ff    <= '0;
         key2_ff    <= '0;
         key3_ff    <= '0;
         key_len_ff <= KeyLenMin;
      end else if (csr_wr) begin
         unique case (paddr[5:3])
            REG_KEY_0_7:   key0_ff    <= pwdata;
            REG_KEY_8_15:  key1_ff    <= pwdata;
            REG_KEY_16_23: key2_ff    <= pwdata;
            REG_KEY_24_28: key3_ff    <= pwdata[39:0];
            REG_KEY_LEN:   key_len_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (paddr[5:3])
         REG_KEY_0_7:   prdata = key0_ff;
         REG_KEY_8_15:  prdata = key1_ff;
         REG_KEY_16_23: prdata = key2_ff;
         REG_KEY_24_28: prdata = {24'd0, key3_ff};
         REG_KEY_LEN:   prdata = {59'd0, key_len_ff};
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // S-box memory: one write and one registered read per cycle
   // ---------------------------------------------------------------------
   logic [7:0] sbox_mem [256];
   logic [7:0] sbox_rd_ff;
   logic       mem_we;
   logic [7:0] mem_waddr, mem_wdata, mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sbox_mem[mem_waddr] <= mem_wdata;
      end
      sbox_rd_ff <= sbox_mem[mem_raddr];
   end

   // ---------------------------------------------------------------------
   // control and working registers
   // ---------------------------------------------------------------------
   logic [2:0]          state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [7:0]          a_ff, a_in;          // first swap address (n or i)
   logic [7:0]          b_ff, b_in;          // second swap address (j)
   logic [7:0]          j_ff, j_in;
   logic [7:0]          i_ff, i_in;
   logic [7:0]          va_ff, va_in;        // value read at address a
   logic [4:0]          kidx_ff, kidx_in;    // key byte index, n mod klen
   logic [5:0]          klen_ff, klen_in;
   logic [IvWidth-1:0]  iv_ff, iv_in;
   logic                err_ff, err_in;
   logic                weak_ff, weak_in;
   logic                restart_ff, restart_in;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [7:0]          fwd_val_ff, fwd_val_in;
   logic [7:0]          ks_ff, ks_in;
   logic [PosWidth-1:0] cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_ks_ff, rsp_ks_in;
   logic                rsp_weak_ff, rsp_weak_in;
   logic [PosWidth-1:0] rsp_pos_ff, rsp_pos_in;

   // key schedule byte: IV bytes first, then the secret bytes
   logic [255:0] secret_vec;
   logic [4:0]   sidx;
   logic [7:0]   key_byte;

   assign secret_vec = {24'd0, key3_ff, key2_ff, key1_ff, key0_ff};
   assign sidx       = kidx_ff - 5'd3;

   always_comb begin
      if (kidx_ff < 5'd3) begin
         unique case (kidx_ff[1:0])
            2'd0:    key_byte = iv_ff[7:0];
            2'd1:    key_byte = iv_ff[15:8];
            default: key_byte = iv_ff[23:16];
         endcase
      end else begin
         key_byte = secret_vec[{sidx, 3'b000} +: 8];
      end
   end

   // clamped key length and weak-IV test on the incoming IV
   logic [4:0] len_clamped;
   logic [5:0] klen_req;
   logic       weak_req;

   always_comb begin
      if (key_len_ff < KeyLenMin) begin
         len_clamped = KeyLenMin;
      end else if (key_len_ff > KeyLenMax) begin
         len_clamped = KeyLenMax;
      end else begin
         len_clamped = key_len_ff;
      end
      klen_req = {1'b0, len_clamped} + 6'd3;
      weak_req = (req.init_vector[15:8] == 8'hFF)
              && (req.init_vector[23:16] >= 8'd3)
              && (req.init_vector[23:16] < {2'b00, klen_req});
   end

   logic out_free;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   logic [7:0] j_next, b_next, t_addr;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      va_in        = va_ff;
      kidx_in      = kidx_ff;
      klen_in      = klen_ff;
      iv_in        = iv_ff;
      err_in       = err_ff;
      weak_in      = weak_ff;
      restart_in   = restart_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_val_in   = fwd_val_ff;
      ks_in        = ks_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_ks_in    = rsp_ks_ff;
      rsp_weak_in  = rsp_weak_ff;
      rsp_pos_in   = rsp_pos_ff;
      mem_we       = 1'b0;
      mem_waddr    = a_ff;
      mem_wdata    = sbox_rd_ff;
      mem_raddr    = a_ff;

      // j update from the value just read at address a
      if (mode_ff == MODE_KSA) begin
         j_next = j_ff + sbox_rd_ff + key_byte;
      end else begin
         j_next = j_ff + sbox_rd_ff;
      end
      b_next = (mode_ff == MODE_ERR) ? ErrAddrB : j_next;
      t_addr = va_ff + sbox_rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.opcode) begin
                  iv_in      = req.init_vector;
                  err_in     = req.inject_error;
                  klen_in    = klen_req;
                  kidx_in    = 5'd0;
                  weak_in    = weak_req;
                  restart_in = 1'b1;
                  a_in       = 8'd0;
                  state_in   = ST_FILL;
               end else begin
                  restart_in = 1'b0;
                  a_in       = i_ff + 8'd1;
                  mode_in    = MODE_PRGA;
                  state_in   = ST_RD_A;
               end
            end
         end
         // identity fill
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = a_ff;
            mem_wdata = a_ff;
            a_in      = a_ff + 8'd1;
            if (a_ff == 8'hFF) begin
               j_in     = 8'd0;
               kidx_in  = 5'd0;
               mode_in  = MODE_KSA;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            mem_raddr = a_ff;
            state_in  = ST_RD_B;
         end
         ST_RD_B: begin
            va_in     = sbox_rd_ff;
            b_in      = b_next;
            mem_raddr = b_next;
            if (mode_ff != MODE_ERR) begin
               j_in = j_next;
            end
            state_in = ST_WR_A;
         end
         // S[a] <= S[b]; also fetch the output entry, forwarding around
         // the two writes of this swap
         ST_WR_A: begin
            mem_we    = 1'b1;
            mem_waddr = a_ff;
            mem_wdata = sbox_rd_ff;
            mem_raddr = t_addr;
            if (t_addr == a_ff) begin
               fwd_hit_in = 1'b1;
               fwd_val_in = sbox_rd_ff;
            end else if (t_addr == b_ff) begin
               fwd_hit_in = 1'b1;
               fwd_val_in = va_ff;
            end else begin
               fwd_hit_in = 1'b0;
               fwd_val_in = va_ff;
            end
            state_in = ST_WR_B;
         end
         // S[b] <= old S[a], then decide what follows
         ST_WR_B: begin
            mem_we    = 1'b1;
            mem_waddr = b_ff;
            mem_wdata = va_ff;
            unique case (mode_ff)
               MODE_KSA: begin
                  a_in     = a_ff + 8'd1;
                  kidx_in  = ({1'b0, kidx_ff} == klen_ff - 6'd1) ? 5'd0
                                                                : kidx_ff + 5'd1;
                  state_in = ST_RD_A;
                  if (a_ff == 8'hFF) begin
                     if (err_ff) begin
                        mode_in = MODE_ERR;
                        a_in    = ErrAddrA;
                     end else begin
                        mode_in = MODE_PRGA;
                        a_in    = 8'd1;
                        j_in    = 8'd0;
                     end
                  end
               end
               MODE_ERR: begin
                  mode_in  = MODE_PRGA;
                  a_in     = 8'd1;
                  j_in     = 8'd0;
                  state_in = ST_RD_A;
               end
               MODE_PRGA: begin
                  ks_in    = fwd_hit_ff ? fwd_val_ff : sbox_rd_ff;
                  i_in     = a_ff;
                  state_in = ST_DELIVER;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         // load the output register once it is free
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ks_in    = ks_ff;
               if (restart_ff) begin
                  rsp_weak_in = weak_ff;
                  rsp_pos_in  = '0;
                  cnt_in      = 12'd1;
               end else begin
                  rsp_weak_in = 1'b0;
                  rsp_pos_in  = cnt_ff;
                  if (cnt_ff != PosMax) begin
                     cnt_in = cnt_ff + 12'd1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_PRGA;
         i_ff         <= '0;
         j_ff         <= '0;
         cnt_ff       <= '0;
         iv_ff        <= '0;
         kidx_ff      <= '0;
         klen_ff      <= 6'd8;
         restart_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         cnt_ff       <= cnt_in;
         iv_ff        <= iv_in;
         kidx_ff      <= kidx_in;
         klen_ff      <= klen_in;
         restart_ff   <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      va_ff       <= va_in;
      err_ff      <= err_in;
      weak_ff     <= weak_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_val_ff  <= fwd_val_in;
      ks_ff       <= ks_in;
      rsp_ks_ff   <= rsp_ks_in;
      rsp_weak_ff <= rsp_weak_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.keystream_byte = rsp_ks_ff;
   assign rsp.weak_iv        = rsp_weak_ff;
   assign rsp.byte_position  = rsp_pos_ff;

`ifndef SYNTHESIS
   // an accepted item always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff != ST_IDLE)
      else $error("accepted item did not leave idle");

   // a weak-IV flag only comes with the restart byte
   a_weak_pos: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.weak_iv |-> rsp.byte_position == '0)
      else $error("weak IV flagged on a byte other than the first");

   // key byte index stays below the schedule key length
   a_kidx_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, kidx_ff} < klen_ff)
      else $error("key byte index out of range");

   // only keystream generation reaches delivery
   a_deliver_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DELIVER |-> mode_ff == MODE_PRGA)
      else $error("delivery outside keystream generation");
`endif

endmodule

>>> sim/tb_wep_rc4_keystream_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wep_rc4_keystream_generator_unit: self-checking bench for the WEP RC4 unit
// Drives restart and next items through the request channel, mirrors the
// key schedule and keystream in a local S-box copy, and checks every response
// field in order. Key registers change between phases over the CSR port.
// ----------------------------------------------------------------------------
module tb_wep_rc4_keystream_generator_unit;
   import wrc4_pkg::*;

   localparam logic OP_NEXT    = 1'b0;
   localparam logic OP_RESTART = 1'b1;
   localparam int   WATCHDOG_LIMIT = 20000;
   localparam int   ITEMS_PER_PHASE = 375;

   typedef struct {
      logic               opcode;
      logic [IvWidth-1:0] init_vector;
      logic               inject_error;
   } wep_request_type;

   typedef struct {
      logic [7:0]          keystream_byte;
      logic                weak_iv;
      logic [PosWidth-1:0] byte_position;
   } keystream_result_type;

   logic clock;
   logic reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   wrc4_req_if req_if ();
   wrc4_rsp_if rsp_if ();

   wep_rc4_keystream_generator_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // stimulus and expectation stores
   wep_request_type      pending_items[$];
   keystream_result_type expected_bytes[$];

   // mirror of the CSRs
   logic [63:0] key_word[4];
   logic [4:0]  key_len_reg;

   // predicted cipher state, set up by every restart
   logic [7:0]          sbox_copy[256];
   logic [7:0]          idx_i;
   logic [7:0]          idx_j;
   logic [PosWidth-1:0] pos_counter;
   logic [IvWidth-1:0]  cur_iv;

   bit no_idle = 1'b0;
   int error_count = 0;
   int items_issued = 0;
   int results_seen = 0;
   int restarts_checked = 0;
   int weak_checked = 0;
   int injected_count = 0;
   int quiet_cycles = 0;

   // clock: 12 ns period
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit take_break();
      return !no_idle && ($urandom_range(99) < 12);
   endfunction

   // secret key length after clamping to 5..29
   function automatic int clamped_key_len();
      if (key_len_reg < KeyLenMin) return int'(KeyLenMin);
      if (key_len_reg > KeyLenMax) return int'(KeyLenMax);
      return int'(key_len_reg);
   endfunction

   // advance the mirrored cipher by one item and return its response
   function automatic keystream_result_type rc4_step(wep_request_type it);
      keystream_result_type r;
      logic [7:0] pkt_key[32];
      logic [7:0] acc;
      logic [7:0] t;
      logic [7:0] top;
      logic [7:0] out_idx;
      logic [63:0] word;
      int klen;
      r.weak_iv = 1'b0;
      if (it.opcode == OP_RESTART) begin
         klen = clamped_key_len() + 3;
         cur_iv = it.init_vector;
         pkt_key[0] = cur_iv[7:0];
         pkt_key[1] = cur_iv[15:8];
         pkt_key[2] = cur_iv[23:16];
         for (int n = 3; n < 32; n++) begin
            word = key_word[(n - 3) >> 3];
            pkt_key[n] = word[8 * ((n - 3) & 7) +: 8];
         end
         // key schedule
         for (int n = 0; n < 256; n++) sbox_copy[n] = 8'(n);
         acc = 8'd0;
         for (int n = 0; n < 256; n++) begin
            acc = acc + sbox_copy[n] + pkt_key[n % klen];
            t = sbox_copy[n];
            sbox_copy[n] = sbox_copy[acc];
            sbox_copy[acc] = t;
         end
         if (it.inject_error) begin
            t = sbox_copy[1];
            sbox_copy[1] = sbox_copy[11];
            sbox_copy[11] = t;
         end
         // FMS weak IV: middle byte 0xFF, top byte in [3, klen)
         top = cur_iv[23:16];
         if (cur_iv[15:8] == 8'hFF && top >= 8'd3 && int'(top) < klen) r.weak_iv = 1'b1;
         idx_i = 8'd0;
         idx_j = 8'd0;
         pos_counter = '0;
      end
      // keystream generation
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox_copy[idx_i];
      t = sbox_copy[idx_i];
      sbox_copy[idx_i] = sbox_copy[idx_j];
      sbox_copy[idx_j] = t;
      out_idx = sbox_copy[idx_i] + sbox_copy[idx_j];
      r.keystream_byte = sbox_copy[out_idx];
      r.byte_position = pos_counter;
      if (pos_counter != PosMax) pos_counter = pos_counter + 1'b1;
      return r;
   endfunction

   // request driver: predicts each accepted item, then offers the next one
   always @(posedge clock) begin
      wep_request_type taken;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken.opcode = req_if.opcode;
            taken.init_vector = req_if.init_vector;
            taken.inject_error = req_if.inject_error;
            expected_bytes.push_back(rc4_step(taken));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() != 0 && !take_break()) begin
               taken = pending_items.pop_front();
               req_if.valid <= 1'b1;
               req_if.opcode <= taken.opcode;
               req_if.init_vector <= taken.init_vector;
               req_if.inject_error <= taken.inject_error;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compares each item against the oldest prediction
   always @(posedge clock) begin
      keystream_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected response item: keystream_byte %0h", rsp_if.keystream_byte);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_if.keystream_byte !== want.keystream_byte) begin
                  $error("keystream_byte: expected %0h, got %0h",
                         want.keystream_byte, rsp_if.keystream_byte);
                  error_count++;
               end
               if (rsp_if.weak_iv !== want.weak_iv) begin
                  $error("weak_iv: expected %0b, got %0b", want.weak_iv, rsp_if.weak_iv);
                  error_count++;
               end
               if (rsp_if.byte_position !== want.byte_position) begin
                  $error("byte_position: expected %0d, got %0d",
                         want.byte_position, rsp_if.byte_position);
                  error_count++;
               end
               if (want.byte_position == '0) restarts_checked++;
               if (want.weak_iv) weak_checked++;
            end
         end
         rsp_if.ready <= !take_break();
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // APB write: setup cycle, access cycle, done when pready is seen
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_KEY_0_7:   key_word[0] = value;
         REG_KEY_8_15:  key_word[1] = value;
         REG_KEY_16_23: key_word[2] = value;
         REG_KEY_24_28: key_word[3] = value & 64'hFF_FFFF_FFFF;
         REG_KEY_LEN:   key_len_reg = value[4:0];
         default: ;
      endcase
   endtask

   task automatic set_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3,
                          input logic [4:0] len);
      csr_write(REG_KEY_0_7, k0);
      csr_write(REG_KEY_8_15, k1);
      csr_write(REG_KEY_16_23, k2);
      csr_write(REG_KEY_24_28, k3);
      csr_write(REG_KEY_LEN, {59'd0, len});
   endtask

   task automatic send(input logic op, input logic [IvWidth-1:0] iv, input logic inj);
      wep_request_type it;
      it.opcode = op;
      it.init_vector = iv;
      it.inject_error = inj;
      pending_items.push_back(it);
      items_issued++;
      if (op == OP_RESTART && inj) injected_count++;
   endtask

   // wait until every queued item has its response, then let the block settle
   task automatic wait_quiet();
      while (results_seen < items_issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [4:0] rand_key_len();
      if ($urandom_range(9) == 0) return 5'($urandom_range(31));
      return 5'($urandom_range(29, 5));
   endfunction

   // restart IV, sometimes shaped around the weak-IV boundary
   function automatic logic [IvWidth-1:0] rand_iv();
      if ($urandom_range(3) == 0)
         return {8'($urandom_range(clamped_key_len() + 4)), 8'hFF, 8'($urandom)};
      return 24'($urandom);
   endfunction

   task automatic random_phase(input int count);
      int sent;
      int run;
      int kind;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         if (kind < 85) begin
            // packet: restart then a run of next items
            send(OP_RESTART, rand_iv(), $urandom_range(7) == 0);
            if ($urandom_range(9) == 0) run = $urandom_range(300, 50);
            else run = $urandom_range(24);
            for (int k = 0; k < run; k++) send(OP_NEXT, 24'($urandom), 1'($urandom));
            sent += run + 1;
         end else if (kind < 93) begin
            // back-to-back restarts
            send(OP_RESTART, 24'($urandom), 1'($urandom));
            send(OP_RESTART, rand_iv(), 1'($urandom));
            sent += 2;
         end else begin
            // stray next items continuing the current stream
            run = $urandom_range(8, 1);
            for (int k = 0; k < run; k++) send(OP_NEXT, 24'($urandom), 1'($urandom));
            sent += run;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      for (int n = 0; n < 4; n++) key_word[n] = '0;
      key_len_reg = KeyLenMin;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: 104-bit key, IV extremes, weak-IV boundaries
      set_key(rand64(), rand64(), rand64(), rand64(), 5'd13);
      send(OP_RESTART, 24'h000000, 1'b0);
      repeat (3) send(OP_NEXT, 24'hFFFFFF, 1'b1);
      send(OP_RESTART, 24'hFFFFFF, 1'b1);
      repeat (2) send(OP_NEXT, 24'h000000, 1'b0);
      send(OP_RESTART, 24'h03FF5A, 1'b0);
      send(OP_NEXT, 24'h000000, 1'b0);
      send(OP_RESTART, 24'h0FFF00, 1'b0);
      send(OP_RESTART, 24'h10FF00, 1'b0);
      send(OP_RESTART, 24'h02FF00, 1'b0);
      send(OP_RESTART, 24'h03FE00, 1'b0);
      send(OP_NEXT, 24'h000000, 1'b0);
      wait_quiet();

      // shortest key, all-zero secret bytes
      set_key('0, '0, '0, '0, KeyLenMin);
      send(OP_RESTART, 24'h07FF11, 1'b1);
      send(OP_NEXT, 24'h000000, 1'b0);
      wait_quiet();

      // longest key, all-ones secret bytes
      set_key('1, '1, '1, '1, KeyLenMax);
      send(OP_RESTART, 24'h1FFF22, 1'b0);
      send(OP_RESTART, 24'h20FF00, 1'b1);
      send(OP_NEXT, 24'h000000, 1'b0);
      wait_quiet();

      // length below the minimum acts as 5
      csr_write(REG_KEY_LEN, 64'd0);
      send(OP_RESTART, 24'h07FF00, 1'b0);
      send(OP_RESTART, 24'h08FF00, 1'b0);
      wait_quiet();

      // length above the maximum acts as 29
      csr_write(REG_KEY_LEN, 64'd31);
      send(OP_RESTART, 24'h1FFFAB, 1'b0);
      send(OP_NEXT, 24'h000000, 1'b0);
      wait_quiet();

      // random phases, each with a fresh key; the third runs without idling
      for (int ph = 0; ph < 4; ph++) begin
         set_key(rand64(), rand64(), rand64(), rand64(), rand_key_len());
         no_idle = (ph == 2);
         random_phase(ITEMS_PER_PHASE);
         wait_quiet();
      end
      no_idle = 1'b0;

      repeat (16) @(posedge clock);
      $display("checked %0d response items: %0d restarts (%0d with injected error),",
               results_seen, restarts_checked, injected_count);
      $display("%0d weak IVs flagged, key lengths 0..31 and long streams up to 300 bytes",
               weak_checked);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
